/* sv/sws_pkg.sv */
// stopwatch with splits: shared transaction types, constants and time packing
// no dependencies

package sws_pkg;

	// time counter widths
	localparam int HUND_W = 7;
	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 8;
	localparam int BTN_W  = 5;
	localparam int SPLIT_W = HOUR_W + MIN_W + SEC_W + HUND_W;

	// rollover limits
	localparam logic [HUND_W-1:0] HUND_LAST = HUND_W'(99);
	localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
	localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);

	// command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// button bit positions
	localparam int BTN_UP     = 0;
	localparam int BTN_DOWN   = 1;
	localparam int BTN_LEFT   = 2;
	localparam int BTN_RIGHT  = 3;
	localparam int BTN_CENTER = 4;

	typedef struct packed {
		logic             command;
		logic [BTN_W-1:0] buttons;
	} sws_in_t;

	typedef struct packed {
		logic [HOUR_W-1:0]  hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [HUND_W-1:0]  hundredths;
		logic               running;
		logic               second_pulse;
		logic [SPLIT_W-1:0] split_one;
		logic [SPLIT_W-1:0] split_two;
	} sws_out_t;

	// hours<<19 | minutes<<13 | seconds<<7 | hundredths
	function automatic logic [SPLIT_W-1:0] pack_time(
		input logic [HOUR_W-1:0] h,
		input logic [MIN_W-1:0]  m,
		input logic [SEC_W-1:0]  s,
		input logic [HUND_W-1:0] c
	);
		return {h, m, s, c};
	endfunction

endpackage

/* sv/stopwatch_with_splits.sv */
// stopwatch with splits: top level, input register, state update, result register
// depends on sws_pkg

// Usage:
// One input channel (item_valid / item_stall / item) carries either a
// hundredth-second tick or a five-bit button sample; one output channel
// (result_valid / result_stall / result) returns exactly one transaction per
// input transaction, in order, showing the time, run flag, pulse and splits
// after that input took effect.
// An accepted input is held in the input register until the output register
// can take its result; the state update then loads that result into the
// output register, from which it is offered.
// Throughput: one transaction per cycle while the receiver does not stall;
// the state update between input register and output register is combinational.
// Reset clears the time, run flag and splits and marks no button sample seen,
// so the first sample always counts as changed.
// When the receiver stalls, the result is held; the input register still
// fills once, then item_stall rises until the output register drains.

module stopwatch_with_splits (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sws_pkg::sws_in_t item,
	output logic             result_valid,
	input  logic             result_stall,
	output sws_pkg::sws_out_t result
);
	import sws_pkg::*;

	// input register stage
	logic    valid_s1;
	sws_in_t item_s1;

	// stopwatch state
	logic [HUND_W-1:0]  hund_q;
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic               run_q;
	logic [SPLIT_W-1:0] split_a_q;
	logic [SPLIT_W-1:0] split_b_q;
	logic [BTN_W-1:0]   prev_btn_q;
	logic               prev_seen_q;

	// output register
	logic     res_valid_q;
	sws_out_t res_q;

	// next-state values
	logic [HUND_W-1:0]  hund_d;
	logic [SEC_W-1:0]   sec_d;
	logic [MIN_W-1:0]   min_d;
	logic [HOUR_W-1:0]  hour_d;
	logic               run_d;
	logic [SPLIT_W-1:0] split_a_d;
	logic [SPLIT_W-1:0] split_b_d;
	logic               pulse_d;
	logic               changed;
	logic [SPLIT_W-1:0] now_packed;

	logic advance;

	// flow control
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// state update for the transaction in the input register
	assign now_packed = pack_time(hour_q, min_q, sec_q, hund_q);
	assign changed    = !prev_seen_q || (item_s1.buttons != prev_btn_q);

	always_comb begin
		hund_d    = hund_q;
		sec_d     = sec_q;
		min_d     = min_q;
		hour_d    = hour_q;
		run_d     = run_q;
		split_a_d = split_a_q;
		split_b_d = split_b_q;
		pulse_d   = 1'b0;
		if (item_s1.command == CMD_TICK) begin
			if (run_q) begin
				if (hund_q == HUND_LAST) begin
					hund_d  = '0;
					pulse_d = 1'b1;
					if (sec_q == SEC_LAST) begin
						sec_d = '0;
						if (min_q == MIN_LAST) begin
							min_d  = '0;
							hour_d = hour_q + HOUR_W'(1);
						end else begin
							min_d = min_q + MIN_W'(1);
						end
					end else begin
						sec_d = sec_q + SEC_W'(1);
					end
				end else begin
					hund_d = hund_q + HUND_W'(1);
				end
			end
		end else if (changed) begin
			run_d = run_q ^ item_s1.buttons[BTN_CENTER];
			if (item_s1.buttons[BTN_LEFT] && run_d) begin
				split_a_d = now_packed;
			end
			if (item_s1.buttons[BTN_RIGHT] && run_d) begin
				split_b_d = now_packed;
			end
			if (item_s1.buttons[BTN_DOWN] && run_d) begin
				hund_d = '0;
				sec_d  = '0;
				min_d  = '0;
				hour_d = '0;
				run_d  = 1'b0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hund_q      <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			run_q       <= 1'b0;
			split_a_q   <= '0;
			split_b_q   <= '0;
			prev_btn_q  <= '0;
			prev_seen_q <= 1'b0;
		end else if (advance) begin
			hund_q    <= hund_d;
			sec_q     <= sec_d;
			min_q     <= min_d;
			hour_q    <= hour_d;
			run_q     <= run_d;
			split_a_q <= split_a_d;
			split_b_q <= split_b_d;
			if (item_s1.command == CMD_SAMPLE) begin
				prev_btn_q  <= item_s1.buttons;
				prev_seen_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.hours        <= hour_d;
			res_q.minutes      <= min_d;
			res_q.seconds      <= sec_d;
			res_q.hundredths   <= hund_d;
			res_q.running      <= run_d;
			res_q.second_pulse <= pulse_d;
			res_q.split_one    <= split_a_d;
			res_q.split_two    <= split_b_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef ASSERT_OFF
	// a rollover pulse always lands on a zero hundredths count
	a_pulse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.second_pulse |-> res_q.hundredths == '0)
		else $error("second pulse without hundredths rollover");

	// only a running watch produces a pulse
	a_pulse_running: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.second_pulse |-> res_q.running)
		else $error("second pulse while stopped");

	// counters stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		hund_q <= HUND_LAST && sec_q <= SEC_LAST && min_q <= MIN_LAST)
		else $error("time counter out of range");

	// an item that moves on always shows up as a result next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advanced item produced no result");
`endif

endmodule

/* sim/tb.sv */
// testbench for stopwatch_with_splits: directed and random tick/button traffic,
// every result checked against an in-bench prediction of the watch state
// depends on sws_pkg and stopwatch_with_splits
`timescale 1ns / 100ps

module tb;
	import sws_pkg::*;

	localparam int IN_W = $bits(sws_in_t);
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1450;
	// unbroken run of ticks, long enough to cross two second carries
	localparam int SPAN_TICKS = 250;

	// button masks
	localparam logic [BTN_W-1:0] B_UP     = BTN_W'(1 << BTN_UP);
	localparam logic [BTN_W-1:0] B_DOWN   = BTN_W'(1 << BTN_DOWN);
	localparam logic [BTN_W-1:0] B_LEFT   = BTN_W'(1 << BTN_LEFT);
	localparam logic [BTN_W-1:0] B_RIGHT  = BTN_W'(1 << BTN_RIGHT);
	localparam logic [BTN_W-1:0] B_CENTER = BTN_W'(1 << BTN_CENTER);
	localparam logic [BTN_W-1:0] B_NONE   = '0;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	sws_in_t  item;
	logic     result_valid;
	logic     result_stall;
	sws_out_t result;

	// predicted watch state
	logic [HUND_W-1:0]  watch_hund  = '0;
	logic [SEC_W-1:0]   watch_sec   = '0;
	logic [MIN_W-1:0]   watch_min   = '0;
	logic [HOUR_W-1:0]  watch_hour  = '0;
	logic               watch_run   = 1'b0;
	logic [SPLIT_W-1:0] watch_lap_a = '0;
	logic [SPLIT_W-1:0] watch_lap_b = '0;
	logic [7:0]         watch_last  = 8'hFF;

	sws_out_t predicted_readings[$];
	sws_out_t due;
	int n_fail = 0;
	int n_sent = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit pace_on = 1'b1;
	int rx_mode;
	int rx_len;

	stopwatch_with_splits u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// apply one transaction to the predicted state, return the expected reading
	function automatic sws_out_t next_reading(input sws_in_t tr);
		sws_out_t r;
		logic pulse;
		pulse = 1'b0;
		if (tr.command == CMD_TICK) begin
			if (watch_run) begin
				if (watch_hund == HUND_LAST) begin
					watch_hund = '0;
					pulse = 1'b1;
					if (watch_sec == SEC_LAST) begin
						watch_sec = '0;
						if (watch_min == MIN_LAST) begin
							watch_min = '0;
							watch_hour = watch_hour + HOUR_W'(1);
						end else begin
							watch_min = watch_min + MIN_W'(1);
						end
					end else begin
						watch_sec = watch_sec + SEC_W'(1);
					end
				end else begin
					watch_hund = watch_hund + HUND_W'(1);
				end
			end
		end else if ({3'b000, tr.buttons} != watch_last) begin
			// changed sample: center, left, right, down in that order
			watch_last = {3'b000, tr.buttons};
			if (tr.buttons[BTN_CENTER])
				watch_run = ~watch_run;
			if (tr.buttons[BTN_LEFT] && watch_run)
				watch_lap_a = {watch_hour, watch_min, watch_sec, watch_hund};
			if (tr.buttons[BTN_RIGHT] && watch_run)
				watch_lap_b = {watch_hour, watch_min, watch_sec, watch_hund};
			if (tr.buttons[BTN_DOWN] && watch_run) begin
				watch_hund = '0;
				watch_sec  = '0;
				watch_min  = '0;
				watch_hour = '0;
				watch_run  = 1'b0;
			end
		end
		r.hours        = watch_hour;
		r.minutes      = watch_min;
		r.seconds      = watch_sec;
		r.hundredths   = watch_hund;
		r.running      = watch_run;
		r.second_pulse = pulse;
		r.split_one    = watch_lap_a;
		r.split_two    = watch_lap_b;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_readings.size() == 0) begin
				$error("result transaction with no expectation waiting");
				n_fail++;
			end else begin
				due = predicted_readings.pop_front();
				check_field("hours", 32'(due.hours), 32'(result.hours));
				check_field("minutes", 32'(due.minutes), 32'(result.minutes));
				check_field("seconds", 32'(due.seconds), 32'(result.seconds));
				check_field("hundredths", 32'(due.hundredths), 32'(result.hundredths));
				check_field("running", 32'(due.running), 32'(result.running));
				check_field("second_pulse", 32'(due.second_pulse),
					32'(result.second_pulse));
				check_field("split_one", 32'(due.split_one), 32'(result.split_one));
				check_field("split_two", 32'(due.split_two), 32'(result.split_two));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// receiver stall pattern: free, sparse, or long runs
	initial begin
		result_stall = 1'b0;
		forever begin
			rx_mode = $urandom_range(0, 2);
			rx_len  = $urandom_range(20, 300);
			repeat (rx_len) begin
				@(negedge clk);
				case (rx_mode)
					0: result_stall = 1'b0;
					1: result_stall = ($urandom_range(0, 3) == 0);
					default: if ($urandom_range(0, 7) == 0) result_stall = ~result_stall;
				endcase
			end
		end
	end

	// send one transaction, idling between bursts while pacing is on
	task automatic send_item(input sws_in_t tr);
		int gap;
		if (pace_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				repeat (gap) begin
					@(negedge clk);
					item_valid = 1'b0;
					item = IN_W'($urandom);
				end
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				                                          : $urandom_range(1, 30);
			end
			burst_left--;
		end
		@(negedge clk);
		item_valid = 1'b1;
		item = tr;
		do @(posedge clk); while (item_stall);
		n_sent++;
		predicted_readings.push_back(next_reading(tr));
	endtask

	task automatic send_sample(input logic [BTN_W-1:0] b);
		sws_in_t tr;
		tr.command = CMD_SAMPLE;
		tr.buttons = b;
		send_item(tr);
	endtask

	// buttons field is ignored on ticks, so fill it with noise
	task automatic send_ticks(input int n);
		sws_in_t tr;
		repeat (n) begin
			tr.command = CMD_TICK;
			tr.buttons = BTN_W'($urandom);
			send_item(tr);
		end
	endtask

	// hold the sender until every expected result has come
	task automatic drain;
		@(negedge clk);
		item_valid = 1'b0;
		while (predicted_readings.size() != 0)
			@(posedge clk);
	endtask

	// stopped watch: ticks, first sample, repeated sample, buttons with no effect
	task automatic test_stopped_watch;
		send_ticks(3);
		send_sample(B_NONE);
		send_sample(B_NONE);
		send_sample(B_LEFT);
		send_sample(B_RIGHT);
		send_sample(B_DOWN);
		send_sample(B_UP);
	endtask

	// button actions and their ordering
	task automatic test_button_actions;
		send_sample(B_NONE);
		send_sample(B_CENTER);
		send_sample(B_CENTER);
		send_ticks(7);
		send_sample(B_LEFT);
		send_ticks(5);
		send_sample(B_RIGHT);
		send_sample(B_LEFT | B_RIGHT | B_UP);
		// center stops first, so down does not clear
		send_sample(B_CENTER | B_DOWN);
		// center starts, left captures, down clears
		send_sample(B_CENTER | B_DOWN | B_LEFT);
		send_sample(B_NONE);
		send_sample(B_CENTER);
		send_ticks(4);
		send_sample(B_DOWN);
		send_sample(5'h1F);
		send_sample(B_NONE);
	endtask

	// second carries on an unbroken run of ticks
	task automatic test_carries;
		pace_on = 1'b0;
		send_sample(B_CENTER);
		send_ticks(99);
		send_ticks(1);
		send_ticks(SPAN_TICKS - 100 + 5);
		send_sample(B_LEFT);
		send_sample(B_DOWN | B_RIGHT);
		send_sample(B_NONE);
		pace_on = 1'b1;
	endtask

	// random sessions: mostly start, tick, split and release, plus noise
	task automatic test_random;
		int pick;
		int n;
		sws_in_t tr;
		n_sent = 0;
		while (n_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				if (!watch_run) begin
					send_sample(B_CENTER | (($urandom_range(0, 3) == 0) ? B_UP : B_NONE));
					send_sample(B_NONE);
				end
				send_ticks($urandom_range(1, ($urandom_range(0, 4) == 0) ? 400 : 120));
				case ($urandom_range(0, 3))
					0: send_sample(B_LEFT);
					1: send_sample(B_RIGHT);
					2: send_sample(B_DOWN);
					default: send_sample(B_LEFT | B_RIGHT);
				endcase
				send_sample(B_NONE);
			end else if (pick < 8) begin
				// presses with no release, sometimes held
				n = $urandom_range(1, 4);
				repeat (n) begin
					tr.command = CMD_SAMPLE;
					tr.buttons = BTN_W'($urandom);
					send_item(tr);
					if ($urandom_range(0, 1) == 0)
						send_item(tr);
				end
			end else begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_item(IN_W'($urandom));
			end
			if ($urandom_range(0, 14) == 0)
				drain();
		end
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stopped_watch();
		drain();
		test_button_actions();
		drain();
		test_carries();
		drain();
		test_random();
		drain();
		repeat (10) @(posedge clk);

		if (n_fail == 0 && predicted_readings.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
